### hdl/slt_pkg.sv
// Shared constants, request and status codes, and the cell command type
// for the sorted list table. No dependencies.
package slt_pkg;

	localparam int DEPTH     = 128;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CAP_W     = 8;
	localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int COUNT_O_W = 8;
	localparam int VAL_W     = 32;
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 2;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

	typedef struct packed {
		logic                    cmp_en;
		logic                    ins_en;
		logic                    del_en;
		logic signed [VAL_W-1:0] value;
	} cell_cmd_t;

endpackage

### hdl/slt_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on slt_pkg for field widths.
interface slt_req_if;
	logic                             valid;
	logic                             ready;
	logic [slt_pkg::REQ_W-1:0]        req_type;
	logic signed [slt_pkg::VAL_W-1:0] value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface slt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [slt_pkg::STATUS_W-1:0]  status;
	logic [slt_pkg::COUNT_O_W-1:0] entry_count;

	modport source (output valid, output hit, output status, output entry_count, input ready);
	modport sink   (input valid, input hit, input status, input entry_count, output ready);
endinterface

### hdl/sorted_list_table_unit.sv
// Sorted list table top level: request sequencer, count and capacity
// registers, response register and the row of slt_cell. Uses slt_pkg, slt_if.
//
// Signed 32-bit values are kept in ascending order in a row of cells, one
// entry per cell. A request passes a compare state, where every cell compares
// its entry with the request value, then an apply state, where the row shifts
// up (insert) or down (remove) in one step and the response is loaded into the
// output register. A new request is taken in the apply state, before the last
// response leaves; a response that is not taken holds the apply state until
// the output register frees. Capacity must be written through cfg_we/cfg_wdata
// only while no request is in flight; the block does not enforce this.
module sorted_list_table_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [slt_pkg::CAP_W-1:0]       cfg_wdata,
	slt_req_if.sink                         req,
	slt_rsp_if.source                       rsp
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CMP   = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0]                          state_q;
	logic [slt_pkg::REQ_W-1:0]           req_q;
	logic signed [slt_pkg::VAL_W-1:0]    value_q;
	logic [slt_pkg::CAP_W-1:0]           capacity_q;
	logic [slt_pkg::CNT_W-1:0]           count_q;
	logic                                rsp_valid_q;
	logic                                rsp_hit_q;
	logic [slt_pkg::STATUS_W-1:0]        rsp_status_q;
	logic [slt_pkg::CNT_W-1:0]           rsp_count_q;

	logic                                slot_free;
	logic                                apply_go;
	logic                                accept;
	logic                                full;
	logic                                hit;
	logic                                ins_ok;
	logic                                del_ok;
	logic                                hit_res;
	logic [slt_pkg::STATUS_W-1:0]        status_res;
	logic [slt_pkg::CNT_W-1:0]           count_nx;
	slt_pkg::cell_cmd_t                  cmd;

	logic signed [slt_pkg::VAL_W-1:0]    entry_vec [slt_pkg::DEPTH];
	logic [slt_pkg::DEPTH-1:0]           le_vec;
	logic [slt_pkg::DEPTH-1:0]           eq_vec;
	logic [slt_pkg::DEPTH-1:0]           valid_vec;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign apply_go  = (state_q == ST_APPLY) && slot_free;
	assign req.ready = (state_q == ST_IDLE) || apply_go;
	assign accept    = req.valid && req.ready;

	assign full = (slt_pkg::CMP_W'(count_q) >= slt_pkg::CMP_W'(capacity_q))
		|| (count_q >= slt_pkg::CNT_W'(slt_pkg::DEPTH));
	assign hit  = |eq_vec;

	always_comb begin
		ins_ok     = 1'b0;
		del_ok     = 1'b0;
		hit_res    = 1'b0;
		status_res = slt_pkg::STATUS_DONE;
		count_nx   = count_q;
		unique case (req_q)
			slt_pkg::REQ_INSERT: begin
				if (full) begin
					status_res = slt_pkg::STATUS_FULL;
				end else begin
					ins_ok   = 1'b1;
					count_nx = count_q + 1'b1;
				end
			end
			slt_pkg::REQ_SEARCH: begin
				hit_res    = hit;
				status_res = hit ? slt_pkg::STATUS_DONE : slt_pkg::STATUS_MISS;
			end
			slt_pkg::REQ_REMOVE: begin
				hit_res = hit;
				if (hit) begin
					del_ok   = 1'b1;
					count_nx = count_q - 1'b1;
				end else begin
					status_res = slt_pkg::STATUS_MISS;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cmd.cmp_en = (state_q == ST_CMP);
		cmd.ins_en = apply_go && ins_ok;
		cmd.del_en = apply_go && del_ok;
		cmd.value  = value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (accept) state_q <= ST_CMP;
					else if (apply_go) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req.req_type;
			value_q <= req.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			capacity_q <= slt_pkg::CAP_RESET;
		end else begin
			if (apply_go) count_q <= count_nx;
			if (cfg_we) capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (apply_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			rsp_hit_q    <= hit_res;
			rsp_status_q <= status_res;
			rsp_count_q  <= count_nx;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = slt_pkg::COUNT_O_W'(rsp_count_q);

	for (genvar i = 0; i < slt_pkg::DEPTH; i++) begin : g_cell
		logic                             prev_le;
		logic signed [slt_pkg::VAL_W-1:0] prev_entry;
		logic signed [slt_pkg::VAL_W-1:0] next_entry;

		assign valid_vec[i] = (count_q > slt_pkg::CNT_W'(i));

		if (i == 0) begin : g_first
			assign prev_le    = 1'b1;
			assign prev_entry = value_q;
		end else begin : g_mid
			assign prev_le    = le_vec[i-1];
			assign prev_entry = entry_vec[i-1];
		end

		if (i == slt_pkg::DEPTH - 1) begin : g_last
			assign next_entry = entry_vec[i];
		end else begin : g_inner
			assign next_entry = entry_vec[i+1];
		end

		slt_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (valid_vec[i]),
			.prev_le    (prev_le),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.entry      (entry_vec[i]),
			.le         (le_vec[i]),
			.eq         (eq_vec[i])
		);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= slt_pkg::CNT_W'(slt_pkg::DEPTH))
		else $error("entry count above table depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not advance the count");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del_en |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not drop the count");

	a_rsp_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_APPLY))
		else $error("response raised outside the apply cycle");

	a_match_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |-> ((eq_vec & ~valid_vec) == '0))
		else $error("match flagged on an empty cell");

endmodule

### hdl/slt_cell.sv
// One storage cell of the sorted row: holds an entry, compares it with the
// broadcast value, and on insert or remove takes the value or a neighbor's entry. Uses slt_pkg.
module slt_cell (
	input  logic                             clk,
	input  slt_pkg::cell_cmd_t               cmd,
	input  logic                             valid,
	input  logic                             prev_le,
	input  logic signed [slt_pkg::VAL_W-1:0] prev_entry,
	input  logic signed [slt_pkg::VAL_W-1:0] next_entry,
	output logic signed [slt_pkg::VAL_W-1:0] entry,
	output logic                             le,
	output logic                             eq
);

	logic signed [slt_pkg::VAL_W-1:0] entry_q;
	logic                             le_q;
	logic                             eq_q;

	always_ff @(posedge clk) begin
		if (cmd.cmp_en) begin
			le_q <= valid && (entry_q <= cmd.value);
			eq_q <= valid && (entry_q == cmd.value);
		end
		if (cmd.ins_en && !le_q) begin
			entry_q <= prev_le ? cmd.value : prev_entry;
		end else if (cmd.del_en && !(le_q && !eq_q)) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign le    = le_q;
	assign eq    = eq_q;

endmodule
